// ----- sv/gregorian_date_day_arithmetic_macros.svh -----
// ----------------------------------------------------------------------------
// gregorian date day arithmetic assertion macros
// shared property forms for the date arithmetic block
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_DAY_ARITHMETIC_MACROS_SVH
`define GREGORIAN_DATE_DAY_ARITHMETIC_MACROS_SVH

// same-cycle implication, off during reset
`define GDDA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked through reset
`define GDDA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/gdda_pkg.sv -----
// ----------------------------------------------------------------------------
// gdda package
// calendar tables, date helpers and shared types for date arithmetic
// ----------------------------------------------------------------------------
package gdda_pkg;

   localparam int SERIAL_W = 22;
   localparam int DIFF_W = 23;
   localparam int OFS_W = 21;
   localparam int YEAR_W = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W = 5;
   localparam int PROD_W = 25;
   localparam logic [SERIAL_W-1:0] LAST_SERIAL = 22'd3652058;
   localparam logic [12:0] RECIP_25 = 13'd5243;

   typedef struct packed {
      logic kind;
      logic same;
      logic a_before;
      logic err;
      logic signed [DIFF_W-1:0] diff;
   } meta_type;

   function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
      case (m)
         4'd1: cum_days = 9'd0;
         4'd2: cum_days = 9'd31;
         4'd3: cum_days = 9'd59;
         4'd4: cum_days = 9'd90;
         4'd5: cum_days = 9'd120;
         4'd6: cum_days = 9'd151;
         4'd7: cum_days = 9'd181;
         4'd8: cum_days = 9'd212;
         4'd9: cum_days = 9'd243;
         4'd10: cum_days = 9'd273;
         4'd11: cum_days = 9'd304;
         4'd12: cum_days = 9'd334;
         default: cum_days = 9'd0;
      endcase
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      case (m)
         4'd2: month_len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
         default: month_len = 5'd0;
      endcase
   endfunction

   // yprod holds (y / 4) * recip, so its top bits are y / 100
   function automatic logic is_leap(input logic [YEAR_W-1:0] y,
                                    input logic [PROD_W-1:0] yprod);
      logic [7:0] qy;
      qy = yprod[24:17];
      is_leap = (y[1:0] == 2'b00) &&
                ((y[13:2] != 12'(qy) * 12'd25) || (qy[1:0] == 2'b00));
   endfunction

   function automatic logic date_ok(input logic [YEAR_W-1:0] y,
                                    input logic [MONTH_W-1:0] m,
                                    input logic [DAY_W-1:0] d,
                                    input logic leap);
      date_ok = (y >= 14'd1) && (y <= 14'd9999) && (m >= 4'd1) && (m <= 4'd12) &&
                (d >= 5'd1) && (d <= month_len(m, leap));
   endfunction

   // pprod holds ((y - 1) / 4) * recip, so its top bits are (y - 1) / 100
   function automatic logic [SERIAL_W-1:0] date_serial(input logic [YEAR_W-1:0] y,
                                                       input logic [MONTH_W-1:0] m,
                                                       input logic [DAY_W-1:0] d,
                                                       input logic [PROD_W-1:0] pprod,
                                                       input logic leap);
      logic [YEAR_W-1:0] p;
      logic [7:0] q100;
      p = y - 14'd1;
      q100 = pprod[24:17];
      date_serial = 22'(p) * 22'd365 + 22'(p[13:2]) - 22'(q100) + 22'(q100[7:2]) +
                    22'(cum_days(m)) + 22'(leap && (m > 4'd2)) + 22'(d) - 22'd1;
   endfunction

endpackage

// ----- sv/gdda_front.sv -----
// ----------------------------------------------------------------------------
// gdda front
// date checks, compare flags and serial day numbers, then add or subtract
// ----------------------------------------------------------------------------
module gdda_front (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_vld,
   input  logic in_kind,
   input  logic [gdda_pkg::YEAR_W-1:0] in_year_a,
   input  logic [gdda_pkg::MONTH_W-1:0] in_month_a,
   input  logic [gdda_pkg::DAY_W-1:0] in_day_a,
   input  logic [gdda_pkg::YEAR_W-1:0] in_year_b,
   input  logic [gdda_pkg::MONTH_W-1:0] in_month_b,
   input  logic [gdda_pkg::DAY_W-1:0] in_day_b,
   input  logic signed [gdda_pkg::OFS_W-1:0] in_offset,
   output logic out_vld,
   output logic [gdda_pkg::SERIAL_W-1:0] out_n,
   output gdda_pkg::meta_type out_meta
);
   import gdda_pkg::*;

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic s1_kind_ff, s2_kind_ff;
   logic s1_same_ff, s2_same_ff, s1_before_ff, s2_before_ff;
   logic [YEAR_W-1:0] s1_ya_ff, s1_yb_ff;
   logic [MONTH_W-1:0] s1_ma_ff, s1_mb_ff;
   logic [DAY_W-1:0] s1_da_ff, s1_db_ff;
   logic signed [OFS_W-1:0] s1_ofs_ff, s2_ofs_ff;
   logic [PROD_W-1:0] s1_pa_ff, s1_pb_ff, s1_ypa_ff, s1_ypb_ff;
   logic [PROD_W-1:0] pa_in, pb_in, ypa_in, ypb_in;
   logic [YEAR_W-1:0] pya, pyb;
   logic same_in, before_in;
   logic leap_a, leap_b;
   logic [SERIAL_W-1:0] s2_sa_ff, s2_sb_ff;
   logic s2_oka_ff, s2_okb_ff;
   logic signed [DIFF_W-1:0] sum_in, dif_in;
   logic [SERIAL_W-1:0] s3_n_ff, n_in;
   meta_type s3_meta_ff, meta_in;

   always_comb begin
      pya = in_year_a - 14'd1;
      pyb = in_year_b - 14'd1;
      pa_in = 25'(pya[13:2]) * 25'(RECIP_25);
      pb_in = 25'(pyb[13:2]) * 25'(RECIP_25);
      ypa_in = 25'(in_year_a[13:2]) * 25'(RECIP_25);
      ypb_in = 25'(in_year_b[13:2]) * 25'(RECIP_25);
      same_in = (in_year_a == in_year_b) && (in_month_a == in_month_b) &&
                (in_day_a == in_day_b);
      if (in_year_a != in_year_b) begin
         before_in = in_year_a < in_year_b;
      end else if (in_month_a != in_month_b) begin
         before_in = in_month_a < in_month_b;
      end else begin
         before_in = in_day_a < in_day_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_kind_ff <= in_kind;
         s1_same_ff <= same_in;
         s1_before_ff <= before_in;
         s1_ya_ff <= in_year_a;
         s1_ma_ff <= in_month_a;
         s1_da_ff <= in_day_a;
         s1_yb_ff <= in_year_b;
         s1_mb_ff <= in_month_b;
         s1_db_ff <= in_day_b;
         s1_ofs_ff <= in_offset;
         s1_pa_ff <= pa_in;
         s1_pb_ff <= pb_in;
         s1_ypa_ff <= ypa_in;
         s1_ypb_ff <= ypb_in;
      end
   end

   assign leap_a = is_leap(s1_ya_ff, s1_ypa_ff);
   assign leap_b = is_leap(s1_yb_ff, s1_ypb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_kind_ff <= s1_kind_ff;
         s2_same_ff <= s1_same_ff;
         s2_before_ff <= s1_before_ff;
         s2_ofs_ff <= s1_ofs_ff;
         s2_sa_ff <= date_serial(s1_ya_ff, s1_ma_ff, s1_da_ff, s1_pa_ff, leap_a);
         s2_sb_ff <= date_serial(s1_yb_ff, s1_mb_ff, s1_db_ff, s1_pb_ff, leap_b);
         s2_oka_ff <= date_ok(s1_ya_ff, s1_ma_ff, s1_da_ff, leap_a);
         s2_okb_ff <= date_ok(s1_yb_ff, s1_mb_ff, s1_db_ff, leap_b);
      end
   end

   always_comb begin
      sum_in = $signed({1'b0, s2_sa_ff}) + 23'(s2_ofs_ff);
      dif_in = $signed({1'b0, s2_sa_ff}) - $signed({1'b0, s2_sb_ff});
      meta_in.kind = s2_kind_ff;
      meta_in.same = s2_same_ff;
      meta_in.a_before = s2_before_ff;
      n_in = '0;
      if (!s2_kind_ff) begin
         meta_in.err = !s2_oka_ff || (sum_in < 23'sd0) ||
                       (sum_in > $signed({1'b0, LAST_SERIAL}));
         meta_in.diff = '0;
         n_in = meta_in.err ? '0 : sum_in[SERIAL_W-1:0];
      end else begin
         meta_in.err = !s2_oka_ff || !s2_okb_ff;
         meta_in.diff = meta_in.err ? '0 : dif_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_n_ff <= n_in;
         s3_meta_ff <= meta_in;
      end
   end

   assign out_vld = s3_vld_ff;
   assign out_n = s3_n_ff;
   assign out_meta = s3_meta_ff;

endmodule

// ----- sv/gdda_back.sv -----
// ----------------------------------------------------------------------------
// gdda back
// serial day number to year, month and day through cycle divisions
// ----------------------------------------------------------------------------
module gdda_back (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_vld,
   input  logic [gdda_pkg::SERIAL_W-1:0] in_n,
   input  gdda_pkg::meta_type in_meta,
   output logic out_vld,
   output logic [gdda_pkg::YEAR_W-1:0] out_year,
   output logic [gdda_pkg::MONTH_W-1:0] out_month,
   output logic [gdda_pkg::DAY_W-1:0] out_day,
   output gdda_pkg::meta_type out_meta
);
   import gdda_pkg::*;

   localparam int NST = 8;

   logic [NST-1:0] vld_ff;
   meta_type meta_ff [NST];

   logic [SERIAL_W-1:0] b1_n_ff;
   logic [36:0] b1_prod_ff;
   logic [4:0] q400_in, b2_q400_ff, b3_q400_ff, b4_q400_ff, b5_q400_ff, b6_q400_ff;
   logic [SERIAL_W-1:0] r1_full;
   logic [17:0] r1_in, b2_r1_ff, b3_r1_ff;
   logic [26:0] b3_prod_ff;
   logic [2:0] c100_est;
   logic [17:0] r2_full;
   logic [1:0] c100_in, b4_c100_ff, b5_c100_ff, b6_c100_ff;
   logic [15:0] r2_in, b4_r2_ff, b5_r2_ff;
   logic [29:0] b5_prod_ff;
   logic [4:0] q4_in, b6_q4_ff;
   logic [15:0] r3_full;
   logic [10:0] r3_in, b6_r3_ff;
   logic [1:0] q1_in;
   logic [8:0] doy_in, b7_doy_ff;
   logic [YEAR_W-1:0] year_in, b7_year_ff, b8_year_ff;
   logic leap_in, b7_leap_ff;
   logic [MONTH_W-1:0] month_in, b8_month_ff;
   logic [DAY_W-1:0] day_in, b8_day_ff;
   logic [8:0] start_m, start_sel;
   logic zero_date;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[0] <= in_meta;
         for (int i = 1; i < NST; i++) begin
            meta_ff[i] <= meta_ff[i-1];
         end
      end
   end

   // n / 146097 estimate
   always_ff @(posedge clock) begin
      if (en) begin
         b1_n_ff <= in_n;
         b1_prod_ff <= 37'(in_n) * 37'd29398;
      end
   end

   always_comb begin
      q400_in = b1_prod_ff[36:32];
      r1_full = b1_n_ff - 22'(q400_in) * 22'd146097;
      if (r1_full >= 22'd146097) begin
         q400_in = q400_in + 5'd1;
         r1_full = r1_full - 22'd146097;
      end
      r1_in = r1_full[17:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b2_q400_ff <= q400_in;
         b2_r1_ff <= r1_in;
         b3_q400_ff <= b2_q400_ff;
         b3_r1_ff <= b2_r1_ff;
         b3_prod_ff <= 27'(b2_r1_ff) * 27'd459;
      end
   end

   // centuries, with the last day of a 400 year cycle folded back
   always_comb begin
      c100_est = b3_prod_ff[26:24];
      r2_full = b3_r1_ff - 18'(c100_est) * 18'd36524;
      if (r2_full >= 18'd36524) begin
         c100_est = c100_est + 3'd1;
         r2_full = r2_full - 18'd36524;
      end
      if (c100_est == 3'd4) begin
         c100_est = 3'd3;
         r2_full = r2_full + 18'd36524;
      end
      c100_in = c100_est[1:0];
      r2_in = r2_full[15:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b4_q400_ff <= b3_q400_ff;
         b4_c100_ff <= c100_in;
         b4_r2_ff <= r2_in;
         b5_q400_ff <= b4_q400_ff;
         b5_c100_ff <= b4_c100_ff;
         b5_r2_ff <= b4_r2_ff;
         b5_prod_ff <= 30'(b4_r2_ff) * 30'd11483;
      end
   end

   always_comb begin
      q4_in = b5_prod_ff[28:24];
      r3_full = b5_r2_ff - 16'(q4_in) * 16'd1461;
      if (r3_full >= 16'd1461) begin
         q4_in = q4_in + 5'd1;
         r3_full = r3_full - 16'd1461;
      end
      r3_in = r3_full[10:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b6_q400_ff <= b5_q400_ff;
         b6_c100_ff <= b5_c100_ff;
         b6_q4_ff <= q4_in;
         b6_r3_ff <= r3_in;
      end
   end

   // years inside a four year group, the fourth one holds the leap day
   always_comb begin
      if (b6_r3_ff >= 11'd1095) begin
         q1_in = 2'd3;
      end else if (b6_r3_ff >= 11'd730) begin
         q1_in = 2'd2;
      end else if (b6_r3_ff >= 11'd365) begin
         q1_in = 2'd1;
      end else begin
         q1_in = 2'd0;
      end
      doy_in = 9'(b6_r3_ff - 11'(q1_in) * 11'd365);
      year_in = 14'(b6_q400_ff) * 14'd400 + 14'(b6_c100_ff) * 14'd100 +
                14'(b6_q4_ff) * 14'd4 + 14'(q1_in) + 14'd1;
      leap_in = (q1_in == 2'd3) && ((b6_q4_ff != 5'd24) || (b6_c100_ff == 2'd3));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b7_doy_ff <= doy_in;
         b7_year_ff <= year_in;
         b7_leap_ff <= leap_in;
      end
   end

   always_comb begin
      month_in = 4'd1;
      start_sel = 9'd0;
      for (int m = 2; m <= 12; m++) begin
         start_m = cum_days(4'(m)) + 9'(b7_leap_ff && (m > 2));
         if (b7_doy_ff >= start_m) begin
            month_in = 4'(m);
            start_sel = start_m;
         end
      end
      day_in = 5'(b7_doy_ff - start_sel + 9'd1);
      zero_date = meta_ff[NST-2].kind || meta_ff[NST-2].err;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b8_year_ff <= zero_date ? '0 : b7_year_ff;
         b8_month_ff <= zero_date ? '0 : month_in;
         b8_day_ff <= zero_date ? '0 : day_in;
      end
   end

   assign out_vld = vld_ff[NST-1];
   assign out_year = b8_year_ff;
   assign out_month = b8_month_ff;
   assign out_day = b8_day_ff;
   assign out_meta = meta_ff[NST-1];

endmodule

// ----- sv/gregorian_date_day_arithmetic.sv -----
// ----------------------------------------------------------------------------
// gregorian date day arithmetic
// adds a day offset to a date or takes the day difference of two dates
// ----------------------------------------------------------------------------
// throughput: one item per cycle while rsp_tready stays high, set by the fully pipelined eleven stage datapath
// a stall on rsp_tready holds every stage in place
// reset clears all stage valid bits, payload registers are not reset
module gregorian_date_day_arithmetic (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // year_a, month_a, day_a, year_b, month_b, day_b, offset
   input  logic [71:0] req_tdata,
   // kind
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // res_year, res_month, res_day, difference, same_date, a_before_b, error
   output logic [55:0] rsp_tdata
);
   import gdda_pkg::*;
   `include "gregorian_date_day_arithmetic_macros.svh"

   logic en;
   logic f_vld, b_vld;
   logic [SERIAL_W-1:0] f_n;
   meta_type f_meta, b_meta;
   logic [YEAR_W-1:0] res_year;
   logic [MONTH_W-1:0] res_month;
   logic [DAY_W-1:0] res_day;

   assign en = !b_vld || rsp_tready;
   assign req_tready = en;

   gdda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_vld     (req_tvalid),
      .in_kind    (req_tuser),
      .in_year_a  (req_tdata[13:0]),
      .in_month_a (req_tdata[17:14]),
      .in_day_a   (req_tdata[22:18]),
      .in_year_b  (req_tdata[36:23]),
      .in_month_b (req_tdata[40:37]),
      .in_day_b   (req_tdata[45:41]),
      .in_offset  ($signed(req_tdata[66:46])),
      .out_vld    (f_vld),
      .out_n      (f_n),
      .out_meta   (f_meta)
   );

   gdda_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_vld    (f_vld),
      .in_n      (f_n),
      .in_meta   (f_meta),
      .out_vld   (b_vld),
      .out_year  (res_year),
      .out_month (res_month),
      .out_day   (res_day),
      .out_meta  (b_meta)
   );

   assign rsp_tvalid = b_vld;
   assign rsp_tdata = {7'd0, b_meta.err, b_meta.a_before, b_meta.same, b_meta.diff,
                       res_day, res_month, res_year};

   `GDDA_ASSERT_IMP(a_err_zero, b_vld && b_meta.err, (res_year == '0) && (b_meta.diff == '0), "error item carries a nonzero result")
   `GDDA_ASSERT_IMP(a_same_order, b_vld && b_meta.same, !b_meta.a_before, "equal dates flagged as ordered")
   `GDDA_ASSERT_IMP(a_date_range, b_vld && (res_year != '0), (res_month >= 4'd1) && (res_month <= 4'd12) && (res_day >= 5'd1), "result date out of range")
   `GDDA_ASSERT_NXT(a_reset_idle, reset, !rsp_tvalid, "rsp valid right after reset")

endmodule

// ----- dv/gregorian_date_day_arithmetic_checker.sv -----
// ----------------------------------------------------------------------------
// gregorian date day arithmetic checker
// watches the req and rsp channels, computes the expected date or day count
// for every accepted item and compares each rsp item field by field
// ----------------------------------------------------------------------------
module gregorian_date_day_arithmetic_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);
   import gdda_pkg::*;

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic signed [22:0] diff;
      logic same;
      logic a_before;
      logic err;
   } date_result_type;

   date_result_type expected_dates[$];

   assign pending = expected_dates.size();

   function automatic bit leap_year(longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic longint month_days(longint y, longint m);
      longint lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m < 1 || m > 12) return 0;
      if (m == 2 && leap_year(y)) return 29;
      return lens[m];
   endfunction

   function automatic bit valid_date(longint y, longint m, longint d);
      if (y < 1 || y > 9999 || m < 1 || m > 12 || d < 1) return 0;
      return d <= month_days(y, m);
   endfunction

   function automatic longint year_start(longint y);
      longint p;
      p = y - 1;
      return 365 * p + p / 4 - p / 100 + p / 400;
   endfunction

   function automatic longint day_number(longint y, longint m, longint d);
      longint s;
      s = year_start(y);
      for (longint k = 1; k < m; k++) s += month_days(y, k);
      return s + d - 1;
   endfunction

   function automatic date_result_type compute_date(logic kind, logic [71:0] d);
      date_result_type r;
      longint ya, ma, da, yb, mb, db, ofs, n, yy, mm;
      ya = longint'(d[13:0]); ma = longint'(d[17:14]); da = longint'(d[22:18]);
      yb = longint'(d[36:23]); mb = longint'(d[40:37]); db = longint'(d[45:41]);
      ofs = longint'($signed(d[66:46]));
      r = '0;
      r.same = (ya == yb) && (ma == mb) && (da == db);
      if (ya != yb) r.a_before = ya < yb;
      else if (ma != mb) r.a_before = ma < mb;
      else r.a_before = da < db;
      if (kind == 1'b0) begin
         if (!valid_date(ya, ma, da)) begin
            r.err = 1'b1;
         end else begin
            n = day_number(ya, ma, da) + ofs;
            if (n < 0 || n > 3652058) begin
               r.err = 1'b1;
            end else begin
               yy = n / 366 + 1;
               while (year_start(yy + 1) <= n) yy++;
               n -= year_start(yy);
               mm = 1;
               while (n >= month_days(yy, mm) && mm < 12) begin
                  n -= month_days(yy, mm);
                  mm++;
               end
               r.year = 14'(yy); r.month = 4'(mm); r.day = 5'(n + 1);
            end
         end
      end else begin
         if (!valid_date(ya, ma, da) || !valid_date(yb, mb, db)) r.err = 1'b1;
         else r.diff = 23'(day_number(ya, ma, da) - day_number(yb, mb, db));
      end
      return r;
   endfunction

   always @(posedge clock) begin
      date_result_type want, got;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_dates.push_back(compute_date(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.year = rsp_tdata[13:0];
            got.month = rsp_tdata[17:14];
            got.day = rsp_tdata[22:18];
            got.diff = rsp_tdata[45:23];
            got.same = rsp_tdata[46];
            got.a_before = rsp_tdata[47];
            got.err = rsp_tdata[48];
            if (expected_dates.size() == 0) begin
               if (fail_count < 10) $display("unexpected rsp item %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_dates.pop_front();
               if (want != got) begin
                  if (fail_count < 10)
                     $display("mismatch: exp y%0d m%0d d%0d diff %0d s%b b%b e%b, ",
                              want.year, want.month, want.day, want.diff, want.same,
                              want.a_before, want.err,
                              "got y%0d m%0d d%0d diff %0d s%b b%b e%b",
                              got.year, got.month, got.day, got.diff, got.same,
                              got.a_before, got.err);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// gregorian date day arithmetic testbench
// drives directed and random date items with random gaps and stalls, a long
// rsp hold-off and a drain pause; the checker predicts and compares
// ----------------------------------------------------------------------------
module testbench;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   int          fail_count;
   int          pending;
   bit          hold_rsp = 0;
   bit          no_idle = 0;

   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_DIFF = 1'b1;

   always #10 clock = ~clock;

   gregorian_date_day_arithmetic u_dut (.*);

   gregorian_date_day_arithmetic_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 0;
      else rsp_tready <= no_idle || ($urandom_range(99) >= 18);
   end

   task automatic send_item(logic kind, logic [13:0] ya, logic [3:0] ma, logic [4:0] da,
                            logic [13:0] yb, logic [3:0] mb, logic [4:0] db,
                            logic [20:0] ofs);
      while (!no_idle && $urandom_range(99) < 18) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {5'b0, ofs, db, mb, yb, da, ma, ya};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random;
      logic [13:0] ya, yb;
      logic [3:0] ma, mb;
      logic [4:0] da, db;
      logic [20:0] ofs;
      int sel;
      sel = $urandom_range(99);
      ya = 14'($urandom_range(1, 9999));
      yb = (sel < 30) ? ya : 14'($urandom_range(1, 9999));
      ma = 4'($urandom_range(1, 12)); mb = (sel < 15) ? ma : 4'($urandom_range(1, 12));
      da = 5'($urandom_range(1, 28)); db = 5'($urandom_range(1, 31));
      if (sel >= 90) begin
         ya = 14'($urandom); ma = 4'($urandom); da = 5'($urandom);
         yb = 14'($urandom); mb = 4'($urandom); db = 5'($urandom);
      end else if (sel >= 80) begin
         da = 5'($urandom_range(28, 31));
      end
      if (sel[0]) ofs = 21'($urandom);
      else ofs = 21'($signed($urandom_range(0, 4000)) - 2000);
      send_item(1'($urandom_range(1)), ya, ma, da, yb, mb, db, ofs);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_item(KIND_ADD, 1, 1, 1, 1, 1, 1, 0);
      send_item(KIND_ADD, 1, 1, 1, 1, 1, 1, -21'sd1);
      send_item(KIND_ADD, 9999, 12, 31, 9999, 12, 31, 1);
      send_item(KIND_ADD, 9999, 12, 31, 1, 1, 1, 21'h100001);
      send_item(KIND_ADD, 2000, 2, 29, 1900, 2, 28, 366);
      send_item(KIND_ADD, 1900, 2, 29, 1, 1, 1, 1);
      send_item(KIND_ADD, 2024, 1, 31, 2024, 2, 1, 29);
      send_item(KIND_ADD, 0, 0, 0, 16383, 15, 31, 21'h0FFFFF);
      send_item(KIND_ADD, 16383, 15, 31, 0, 0, 0, 21'h100000);
      send_item(KIND_ADD, 5000, 6, 15, 5000, 6, 16, 21'h0FFFFF);
      send_item(KIND_ADD, 5000, 6, 15, 5000, 6, 14, 21'h100001);
      send_item(KIND_DIFF, 9999, 12, 31, 1, 1, 1, 0);
      send_item(KIND_DIFF, 1, 1, 1, 9999, 12, 31, 0);
      send_item(KIND_DIFF, 2000, 3, 1, 2000, 2, 29, 0);
      send_item(KIND_DIFF, 2100, 2, 29, 2000, 2, 29, 0);
      send_item(KIND_DIFF, 2000, 2, 29, 2100, 2, 29, 0);
      send_item(KIND_DIFF, 2024, 4, 31, 2024, 4, 30, 0);
      send_item(KIND_DIFF, 2024, 13, 1, 2024, 12, 0, 0);
      send_item(KIND_DIFF, 1600, 12, 31, 1600, 12, 31, 0);
      no_idle = 1;
      repeat (200) send_random();
      no_idle = 0;
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (600) send_random();
      hold_rsp = 1;
      fork
         begin
            repeat (200) @(posedge clock);
            hold_rsp = 0;
         end
         repeat (60) send_random();
      join
      repeat (540) send_random();
      req_tvalid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0) $display("PASS gregorian_date_day_arithmetic");
      else $display("FAIL gregorian_date_day_arithmetic");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL gregorian_date_day_arithmetic");
      $finish;
   end
endmodule
